// ===== rtl/nvmrec_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nvmrec_pkg: shared definitions for the record allocator
// Sizes of the record table and the occupancy map, status codes, and the
// types passed between the word scanner and the sequencer.
// ----------------------------------------------------------------------------
package nvmrec_pkg;

  // Store geometry
  localparam int TABLE_SLOTS = 16;
  localparam int STORE_BYTES = 1024;
  localparam int WORD_BITS   = 16;
  localparam int MAP_WORDS   = STORE_BYTES / WORD_BITS;

  // Widths
  localparam int SLOT_W = $clog2(TABLE_SLOTS);
  localparam int BYTE_W = $clog2(STORE_BYTES);
  localparam int WORD_W = $clog2(MAP_WORDS);
  localparam int BIT_W  = $clog2(WORD_BITS);
  localparam int CNT_W  = BIT_W + 1;
  localparam int LEN_W  = 11;
  localparam int RUN_W  = BYTE_W + 1;
  localparam int CSUM_W = 16;

  // Status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_TABLE_FULL = 2'd1;
  localparam logic [1:0] ST_NO_SPACE   = 2'd2;

  // Outcome of scanning one map word
  typedef struct packed {
    logic             hit;
    logic             from_carry;
    logic [BIT_W-1:0] offset;
    logic [RUN_W-1:0] run_out;
  } scan_res_t;

  // One record table entry
  typedef struct packed {
    logic [BYTE_W-1:0] start;
    logic [LEN_W-1:0]  length;
    logic              read_only;
    logic              redundant;
    logic [BYTE_W-1:0] copy_start;
    logic              valid;
    logic [CSUM_W-1:0] checksum;
  } slot_rec_t;

endpackage

// ===== rtl/nvmrec_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nvmrec_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module nvmrec_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/nvmrec_word_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nvmrec_word_scan: free-run search over one occupancy word
// Given the free run carried in from lower words, tells whether a run of the
// requested length completes in this word and where it starts, and what run
// carries on to the next word.
// ----------------------------------------------------------------------------
module nvmrec_word_scan
  import nvmrec_pkg::*;
(
  input  logic [WORD_BITS-1:0] word,
  input  logic [RUN_W-1:0]     run_in,
  input  logic [RUN_W-1:0]     total,
  output scan_res_t            res
);

  logic [CNT_W-1:0]     lead;
  logic [CNT_W-1:0]     top;
  logic                 seen_lo;
  logic                 seen_hi;
  logic [RUN_W:0]       carry_sum;
  logic                 carry_hit;
  logic                 small_req;
  logic [WORD_BITS:0]   win_wide;
  logic [WORD_BITS-1:0] win;
  logic                 int_hit;
  logic [BIT_W-1:0]     int_pos;

  // Count free bits from the bottom and from the top
  always_comb begin
    lead    = CNT_W'(WORD_BITS);
    top     = CNT_W'(WORD_BITS);
    seen_lo = 1'b0;
    seen_hi = 1'b0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (!seen_lo && word[i]) begin
        lead    = CNT_W'(i);
        seen_lo = 1'b1;
      end
    end
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!seen_hi && word[i]) begin
        top     = CNT_W'(WORD_BITS - 1 - i);
        seen_hi = 1'b1;
      end
    end
  end

  // Run carried from below completes here
  assign carry_sum = {1'b0, run_in} + (RUN_W + 1)'(lead);
  assign carry_hit = carry_sum >= {1'b0, total};

  // Window mask for a request that fits inside one word
  assign small_req = total <= RUN_W'(WORD_BITS);
  assign win_wide  = ((WORD_BITS + 1)'(1) << total[CNT_W-1:0]) - (WORD_BITS + 1)'(1);
  assign win       = win_wide[WORD_BITS-1:0];

  // Lowest window fully inside the word
  always_comb begin
    int_hit = 1'b0;
    int_pos = '0;
    for (int s = WORD_BITS - 1; s >= 0; s--) begin
      if (small_req && (s + int'(total) <= WORD_BITS) &&
          ((word & (win << s)) == '0)) begin
        int_hit = 1'b1;
        int_pos = BIT_W'(s);
      end
    end
  end

  // Combine: the carried run always starts lower
  always_comb begin
    res.hit        = carry_hit || int_hit;
    res.from_carry = carry_hit;
    res.offset     = int_pos;
    if (lead == CNT_W'(WORD_BITS)) begin
      res.run_out = run_in + RUN_W'(WORD_BITS);
    end else begin
      res.run_out = RUN_W'(top);
    end
  end

endmodule

// ===== rtl/nvm_record_first_fit_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nvm_record_first_fit_allocator: first-fit record allocator
// Takes an add request, picks the lowest unused record slot, finds the lowest
// free run of the record length (doubled for a redundant copy) in the byte
// occupancy map, marks it taken, and reports status, slot and placement.
//
//   channel  | handshake           | fields
//   ---------+---------------------+-----------------------------------------
//   request  | start, busy         | record_length, read_only_first, keep_copy
//   result   | done (one cycle)    | status, record_id, start_byte,
//            |                     | copy_start_byte
//
// Table full or bad length: result in the next cycle, busy stays low.
// Otherwise the scanner reads one 16-bit map word a cycle until a hit or, with
// no space, the last map word. Marking the run then reads and writes back each
// map word it touches, and the result follows.
// Reset is synchronous and clears slot usage and the map row valid bits at
// once; no clearing pass. The receiver cannot stall: done lasts one cycle.
// ----------------------------------------------------------------------------
module nvm_record_first_fit_allocator
  import nvmrec_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [LEN_W-1:0]  record_length,
  input  logic              read_only_first,
  input  logic              keep_copy,
  output logic              done,
  output logic [1:0]        status,
  output logic [SLOT_W-1:0] record_id,
  output logic [BYTE_W-1:0] start_byte,
  output logic [BYTE_W-1:0] copy_start_byte
);

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_SCAN    = 2'd1;
  localparam logic [1:0] S_MARK_RD = 2'd2;
  localparam logic [1:0] S_MARK_WR = 2'd3;

  logic [1:0]             state;
  logic [TABLE_SLOTS-1:0] slot_used;
  logic [MAP_WORDS-1:0]   row_ok;
  logic [WORD_W:0]        issue;
  logic                   eval_valid;
  logic [WORD_W-1:0]      eval_word;
  logic [RUN_W-1:0]       run;
  logic [LEN_W-1:0]       req_len;
  logic [RUN_W-1:0]       req_total;
  logic                   req_ro;
  logic                   req_keep;
  logic [SLOT_W-1:0]      req_slot;
  logic [BYTE_W-1:0]      start_pos;
  logic [BYTE_W-1:0]      end_pos;
  logic [WORD_W-1:0]      mark_word;

  logic                   accept;
  logic                   any_free;
  logic [SLOT_W-1:0]      free_idx;
  logic [LEN_W:0]         total_in;
  logic [WORD_W-1:0]      map_raddr;
  logic [WORD_BITS-1:0]   map_rdata;
  logic [WORD_W-1:0]      rd_row;
  logic [WORD_BITS-1:0]   cur_word;
  scan_res_t              scan_res;
  logic [BYTE_W-1:0]      word_base;
  logic [BYTE_W-1:0]      found_start;
  logic [RUN_W-1:0]       found_end;
  logic [BIT_W-1:0]       mask_lo;
  logic [BIT_W-1:0]       mask_hi;
  logic [WORD_BITS-1:0]   mark_mask;
  logic                   map_we;
  logic                   slot_we;
  slot_rec_t              slot_rec;
  logic [BYTE_W-1:0]      copy_pos;

  assign busy   = state != S_IDLE;
  assign accept = start && !busy;

  // Pick the lowest unused slot
  always_comb begin
    free_idx = '0;
    for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
      if (!slot_used[i]) begin
        free_idx = SLOT_W'(i);
      end
    end
  end
  assign any_free = ~&slot_used;
  assign total_in = keep_copy ? {record_length, 1'b0} : {1'b0, record_length};

  // Map read address and the word as seen through the row valid bits
  assign map_raddr = (state == S_SCAN) ? issue[WORD_W-1:0] : mark_word;
  assign rd_row    = (state == S_SCAN) ? eval_word : mark_word;
  assign cur_word  = row_ok[rd_row] ? map_rdata : '0;

  nvmrec_word_scan u_scan (
    .word   (cur_word),
    .run_in (run),
    .total  (req_total),
    .res    (scan_res)
  );

  // Start and end of a hit in the word under evaluation
  assign word_base   = {eval_word, {BIT_W{1'b0}}};
  assign found_start = scan_res.from_carry ? word_base - run[BYTE_W-1:0]
                                           : word_base | BYTE_W'(scan_res.offset);
  assign found_end   = {1'b0, found_start} + req_total - RUN_W'(1);

  // Bits of the current word that fall inside the run
  assign mask_lo   = (mark_word == start_pos[BYTE_W-1:BIT_W]) ? start_pos[BIT_W-1:0] : '0;
  assign mask_hi   = (mark_word == end_pos[BYTE_W-1:BIT_W]) ? end_pos[BIT_W-1:0] : '1;
  assign mark_mask = ({WORD_BITS{1'b1}} << mask_lo) &
                     ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - mask_hi));

  assign map_we  = state == S_MARK_WR;
  assign slot_we = map_we && (mark_word == end_pos[BYTE_W-1:BIT_W]);

  nvmrec_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk     (clk),
    .wr_en   (map_we),
    .wr_addr (mark_word),
    .wr_data (cur_word | mark_mask),
    .rd_addr (map_raddr),
    .rd_data (map_rdata)
  );

  // Record table entry written on success
  assign copy_pos = req_keep ? start_pos + req_len[BYTE_W-1:0] : '0;
  always_comb begin
    slot_rec.start      = start_pos;
    slot_rec.length     = req_len;
    slot_rec.read_only  = req_ro;
    slot_rec.redundant  = req_keep;
    slot_rec.copy_start = copy_pos;
    slot_rec.valid      = 1'b0;
    slot_rec.checksum   = '0;
  end

  nvmrec_ram #(
    .WIDTH ($bits(slot_rec_t)),
    .DEPTH (TABLE_SLOTS)
  ) u_slots (
    .clk     (clk),
    .wr_en   (slot_we),
    .wr_addr (req_slot),
    .wr_data (slot_rec),
    .rd_addr (req_slot),
    .rd_data ()
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      slot_used  <= '0;
      row_ok     <= '0;
      done       <= 1'b0;
      eval_valid <= 1'b0;
      issue      <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            req_len   <= record_length;
            req_total <= total_in[RUN_W-1:0];
            req_ro    <= read_only_first;
            req_keep  <= keep_copy;
            req_slot  <= free_idx;
            if (!any_free) begin
              done            <= 1'b1;
              status          <= ST_TABLE_FULL;
              record_id       <= '0;
              start_byte      <= '0;
              copy_start_byte <= '0;
            end else if (record_length == '0 ||
                         total_in > (LEN_W + 1)'(STORE_BYTES)) begin
              done            <= 1'b1;
              status          <= ST_NO_SPACE;
              record_id       <= '0;
              start_byte      <= '0;
              copy_start_byte <= '0;
            end else begin
              state      <= S_SCAN;
              issue      <= '0;
              eval_valid <= 1'b0;
              run        <= '0;
            end
          end
        end
        S_SCAN: begin
          // Issue the next word read, evaluate the one returned
          if (issue < (WORD_W + 1)'(MAP_WORDS)) begin
            issue <= issue + 1'b1;
          end
          eval_valid <= issue < (WORD_W + 1)'(MAP_WORDS);
          eval_word  <= issue[WORD_W-1:0];
          if (eval_valid) begin
            if (scan_res.hit) begin
              start_pos <= found_start;
              end_pos   <= found_end[BYTE_W-1:0];
              mark_word <= found_start[BYTE_W-1:BIT_W];
              state     <= S_MARK_RD;
            end else if (eval_word == WORD_W'(MAP_WORDS - 1)) begin
              done            <= 1'b1;
              status          <= ST_NO_SPACE;
              record_id       <= '0;
              start_byte      <= '0;
              copy_start_byte <= '0;
              state           <= S_IDLE;
            end else begin
              run <= scan_res.run_out;
            end
          end
        end
        S_MARK_RD: begin
          state <= S_MARK_WR;
        end
        S_MARK_WR: begin
          // Write back the marked word, then advance or finish
          row_ok[mark_word] <= 1'b1;
          if (slot_we) begin
            slot_used[req_slot] <= 1'b1;
            done                <= 1'b1;
            status              <= ST_OK;
            record_id           <= req_slot;
            start_byte          <= start_pos;
            copy_start_byte     <= copy_pos;
            state               <= S_IDLE;
          end else begin
            mark_word <= mark_word + 1'b1;
            state     <= S_MARK_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Error results carry no placement
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_OK |-> record_id == '0 && start_byte == '0 &&
                                copy_start_byte == '0)
    else $error("error result with nonzero placement");

  // A success comes only out of the last map write
  a_ok_from_mark: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_OK |-> $past(state) == S_MARK_WR)
    else $error("success result without marking the run");

  // Each success takes exactly one more slot
  a_slot_count: assert property (@(posedge clk) disable iff (rst)
    slot_we |=> $countones(slot_used) == $past($countones(slot_used)) + 1)
    else $error("slot usage did not grow by one");

  // No copy start without a redundant copy
  a_no_copy: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_OK && !req_keep |-> copy_start_byte == '0)
    else $error("copy start reported without a copy");

endmodule

// ===== tb/sv/nvm_record_first_fit_allocator_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nvm_record_first_fit_allocator_test: self-checking bench for the allocator
// Starts with a short table of add requests covering the bad-length cases and
// the first placements. A random phase follows that places records spread over
// the run until the record table fills, mixed with requests that cannot fit.
// A shadow copy of the slot table and the byte map predicts every answer, and
// each done strobe is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module nvm_record_first_fit_allocator_test;
  import nvmrec_pkg::*;

  localparam int ITEMS        = 750;
  localparam int PLAN_ROWS    = 12;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 200;

  // Expected answer to one add request
  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] id;
    logic [BYTE_W-1:0] start;
    logic [BYTE_W-1:0] copy;
  } placement_t;

  // One row of the directed request table
  typedef struct packed {
    logic [LEN_W-1:0] length;
    logic             read_only;
    logic             copy;
    bit               typed;
    placement_t       want;
  } plan_row_t;

  // Shapes of random requests
  typedef enum int {
    REQ_FIT              = 0,
    REQ_ZERO             = 1,
    REQ_OVERSIZE         = 2,
    REQ_DOUBLED_OVERSIZE = 3,
    REQ_CROWDED          = 4,
    REQ_ANY              = 5
  } request_kind_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              start;
  logic              busy;
  logic [LEN_W-1:0]  record_length;
  logic              read_only_first;
  logic              keep_copy;
  logic              done;
  logic [1:0]        status;
  logic [SLOT_W-1:0] record_id;
  logic [BYTE_W-1:0] start_byte;
  logic [BYTE_W-1:0] copy_start_byte;

  // Shadow state of the allocator
  bit         slot_taken [TABLE_SLOTS];
  bit         map_taken [STORE_BYTES];
  slot_rec_t  shadow_table [TABLE_SLOTS];
  int         bytes_used = 0;
  int         slots_used = 0;

  placement_t pending_placements [$];
  placement_t oldest_placement;
  int         mismatch_count = 0;
  int         requests_sent = 0;
  int         placed_seen = 0;
  int         full_seen = 0;
  int         no_space_seen = 0;
  int         idle_pct = 15;
  int         cycle_count = 0;

  always #1 clk = ~clk;

  nvm_record_first_fit_allocator dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .record_length   (record_length),
    .read_only_first (read_only_first),
    .keep_copy       (keep_copy),
    .done            (done),
    .status          (status),
    .record_id       (record_id),
    .start_byte      (start_byte),
    .copy_start_byte (copy_start_byte)
  );

  // Place one record in the shadow state and return the expected answer
  function automatic placement_t place_record(input logic [LEN_W-1:0] length,
                                              input logic ro, input logic copy);
    placement_t res;
    int         slot;
    int         total;
    int         run;
    int         first;
    res   = '0;
    slot  = -1;
    run   = 0;
    first = -1;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      if (!slot_taken[i] && slot < 0) slot = i;
    end
    if (slot < 0) begin
      res.status = ST_TABLE_FULL;
      return res;
    end
    res.status = ST_NO_SPACE;
    total = copy ? 2 * int'(length) : int'(length);
    if (length == '0 || total > STORE_BYTES) return res;
    // take the lowest free run, which may end at the last byte
    for (int i = 0; i < STORE_BYTES && first < 0; i++) begin
      if (map_taken[i]) begin
        run = 0;
      end else begin
        run++;
        if (run == total) first = i + 1 - total;
      end
    end
    if (first < 0) return res;
    for (int k = first; k < first + total; k++) map_taken[k] = 1'b1;
    slot_taken[slot] = 1'b1;
    bytes_used += total;
    slots_used++;
    res.status = ST_OK;
    res.id     = SLOT_W'(slot);
    res.start  = BYTE_W'(first);
    res.copy   = copy ? BYTE_W'(first + int'(length)) : '0;
    shadow_table[slot] = '{start: res.start, length: length, read_only: ro,
                           redundant: copy, copy_start: res.copy, valid: 1'b0,
                           checksum: '0};
    return res;
  endfunction

  task automatic flag_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  // Drive one add request, hold it until taken, then queue its answer
  task automatic send_request(input logic [LEN_W-1:0] length, input logic ro,
                              input logic copy, input bit typed,
                              input placement_t want);
    placement_t predicted;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start           <= 1'b1;
    record_length   <= length;
    read_only_first <= ro;
    keep_copy       <= copy;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = place_record(length, ro, copy);
    pending_placements.push_back(typed ? want : predicted);
    requests_sent++;
  endtask

  // Check each answer against the oldest expectation
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_placements.size() == 0) begin
        flag_mismatch("answer with no request waiting");
      end else begin
        oldest_placement = pending_placements.pop_front();
        if (status !== oldest_placement.status)
          flag_mismatch($sformatf("status %0d, expected %0d",
                                  status, oldest_placement.status));
        if (record_id !== oldest_placement.id)
          flag_mismatch($sformatf("record_id %0d, expected %0d",
                                  record_id, oldest_placement.id));
        if (start_byte !== oldest_placement.start)
          flag_mismatch($sformatf("start_byte %0d, expected %0d",
                                  start_byte, oldest_placement.start));
        if (copy_start_byte !== oldest_placement.copy)
          flag_mismatch($sformatf("copy_start_byte %0d, expected %0d",
                                  copy_start_byte, oldest_placement.copy));
      end
      case (status)
        ST_OK:         placed_seen++;
        ST_TABLE_FULL: full_seen++;
        default:       no_space_seen++;
      endcase
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    plan_row_t     plan [PLAN_ROWS];
    placement_t    none;
    request_kind_t kind;
    logic [LEN_W-1:0] length;
    logic          ro;
    logic          copy;
    int            free_bytes;
    int            cap;
    int            total;

    none = '0;
    rst             <= 1'b1;
    start           <= 1'b0;
    record_length   <= '0;
    read_only_first <= 1'b0;
    keep_copy       <= 1'b0;

    // bad lengths first: they must leave the table and the map untouched
    plan[0]  = '{11'd0,    1'b0, 1'b0, 1'b1, '{ST_NO_SPACE, 4'd0, 10'd0, 10'd0}};
    plan[1]  = '{11'd0,    1'b1, 1'b1, 1'b1, '{ST_NO_SPACE, 4'd0, 10'd0, 10'd0}};
    plan[2]  = '{11'd1025, 1'b0, 1'b0, 1'b1, '{ST_NO_SPACE, 4'd0, 10'd0, 10'd0}};
    plan[3]  = '{11'd2047, 1'b1, 1'b1, 1'b1, '{ST_NO_SPACE, 4'd0, 10'd0, 10'd0}};
    plan[4]  = '{11'd513,  1'b0, 1'b1, 1'b1, '{ST_NO_SPACE, 4'd0, 10'd0, 10'd0}};
    plan[5]  = '{11'd1024, 1'b1, 1'b1, 1'b1, '{ST_NO_SPACE, 4'd0, 10'd0, 10'd0}};
    // first placement after reset lands at slot 0, byte 0
    plan[6]  = '{11'd1,    1'b0, 1'b0, 1'b1, '{ST_OK, 4'd0, 10'd0, 10'd0}};
    plan[7]  = '{11'd1,    1'b1, 1'b1, 1'b0, none};
    plan[8]  = '{11'd3,    1'b0, 1'b1, 1'b0, none};
    // runs that no longer fit behind the placed records
    plan[9]  = '{11'd1024, 1'b0, 1'b0, 1'b0, none};
    plan[10] = '{11'd1016, 1'b1, 1'b0, 1'b0, none};
    plan[11] = '{11'd508,  1'b0, 1'b1, 1'b0, none};

    repeat (5) @(negedge clk);
    rst <= 1'b0;

    for (int r = 0; r < PLAN_ROWS; r++) begin
      send_request(plan[r].length, plan[r].read_only, plan[r].copy,
                   plan[r].typed, plan[r].want);
    end

    // Spread placements over the run, mixed with requests that cannot fit
    for (int n = PLAN_ROWS; n < ITEMS; n++) begin
      idle_pct = (n < ITEMS / 3) ? 15 : (n < 2 * ITEMS / 3) ? 55 : 0;
      if (slots_used < TABLE_SLOTS)
        kind = ($urandom_range(44) == 0) ? REQ_FIT
                                         : request_kind_t'($urandom_range(5, 1));
      else
        kind = REQ_ANY;
      ro         = 1'($urandom_range(1));
      copy       = 1'($urandom_range(1));
      free_bytes = STORE_BYTES - bytes_used;
      case (kind)
        REQ_FIT: begin
          // the last slot takes the rest of the store, ending at the last byte unless a copy halves an odd total
          if (free_bytes == 0) begin
            total = 1;
          end else if (slots_used == TABLE_SLOTS - 1) begin
            total = free_bytes;
          end else begin
            cap = free_bytes / (TABLE_SLOTS - slots_used);
            if (cap < 1) cap = 1;
            total = $urandom_range(cap, 1);
          end
          if (copy && total >= 2) begin
            length = LEN_W'(total / 2);
          end else begin
            copy   = 1'b0;
            length = LEN_W'(total);
          end
        end
        REQ_ZERO: length = '0;
        REQ_OVERSIZE: length = LEN_W'($urandom_range(2047, STORE_BYTES + 1));
        REQ_DOUBLED_OVERSIZE: begin
          copy   = 1'b1;
          length = LEN_W'($urandom_range(STORE_BYTES, STORE_BYTES / 2 + 1));
        end
        REQ_CROWDED: begin
          copy = 1'b0;
          if (free_bytes < STORE_BYTES)
            length = LEN_W'($urandom_range(STORE_BYTES, free_bytes + 1));
          else
            length = LEN_W'($urandom_range(2047));
        end
        default: length = LEN_W'($urandom_range(2047));
      endcase
      send_request(length, ro, copy, 1'b0, none);
    end

    // Drop start, then wait out every answer and a quiet stretch
    @(negedge clk);
    start <= 1'b0;
    while (pending_placements.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d add requests: %0d placed, %0d table full, %0d no space",
             requests_sent, placed_seen, full_seen, no_space_seen);
    $display("Store bytes used %0d of %0d, slots used %0d of %0d, mismatches %0d",
             bytes_used, STORE_BYTES, slots_used, TABLE_SLOTS, mismatch_count);
    if (mismatch_count == 0 && pending_placements.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
